// ===== design/wsrq_pkg.sv =====
`timescale 1ns / 1ps
package wsrq_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 16;
	localparam int PAY_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic REG_DUP_ALLOWED = 1'b0;

	localparam logic [3:0] DP_NOP        = 4'd0;
	localparam logic [3:0] DP_LOAD       = 4'd1;
	localparam logic [3:0] DP_SET_STATUS = 4'd2;
	localparam logic [3:0] DP_SCAN_START = 4'd3;
	localparam logic [3:0] DP_SCAN_STEP  = 4'd4;
	localparam logic [3:0] DP_FOUND      = 4'd5;
	localparam logic [3:0] DP_APPEND     = 4'd6;
	localparam logic [3:0] DP_SHIFT_STEP = 4'd7;
	localparam logic [3:0] DP_PLACE      = 4'd8;
	localparam logic [3:0] DP_POP_START  = 4'd9;
	localparam logic [3:0] DP_POP_STEP   = 4'd10;
	localparam logic [3:0] DP_POP_ONE    = 4'd11;
	localparam logic [3:0] DP_EMIT       = 4'd12;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] entry_count;
		logic             head_valid;
		logic [KEY_W-1:0] head_key;
		logic [PAY_W-1:0] head_payload;
		logic             keys_consecutive;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       occ_zero;
		logic       occ_one;
		logic       occ_full;
		logic       dup_hit;
		logic       ahead;
		logic       idx_at_end;
		logic       idx_at_pos;
		logic       out_free;
	} dp_stat_t;

	// High when b neither repeats a nor follows it by one, with wrap.
	function automatic logic key_break(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic [KEY_W-1:0] a_inc;
		a_inc = a + KEY_W'(1);
		return !((b == a) || (b == a_inc));
	endfunction

endpackage

// ===== design/wsrq_ctrl.sv =====
`timescale 1ns / 1ps
module wsrq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  wsrq_pkg::dp_stat_t stat,
	output wsrq_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_PLACE  = 3'd4;
	localparam logic [2:0] S_POP    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = wsrq_pkg::DP_NOP;
		cmd.code  = wsrq_pkg::ST_OK;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op    = wsrq_pkg::DP_LOAD;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.command == wsrq_pkg::CMD_INSERT) begin
					priority if (stat.occ_full) begin
						cmd.op    = wsrq_pkg::DP_SET_STATUS;
						cmd.code  = wsrq_pkg::ST_FULL;
						state_nxt = S_DONE;
					end else if (stat.occ_zero) begin
						cmd.op    = wsrq_pkg::DP_APPEND;
						state_nxt = S_DONE;
					end else begin
						cmd.op    = wsrq_pkg::DP_SCAN_START;
						state_nxt = S_SCAN;
					end
				end else if (stat.command == wsrq_pkg::CMD_POP) begin
					priority if (stat.occ_zero) begin
						cmd.op    = wsrq_pkg::DP_SET_STATUS;
						cmd.code  = wsrq_pkg::ST_EMPTY;
						state_nxt = S_DONE;
					end else if (stat.occ_one) begin
						cmd.op    = wsrq_pkg::DP_POP_ONE;
						state_nxt = S_DONE;
					end else begin
						cmd.op    = wsrq_pkg::DP_POP_START;
						state_nxt = S_POP;
					end
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_SCAN: begin
				priority if (stat.dup_hit) begin
					cmd.op    = wsrq_pkg::DP_SET_STATUS;
					cmd.code  = wsrq_pkg::ST_DUP;
					state_nxt = S_DONE;
				end else if (stat.ahead) begin
					cmd.op    = wsrq_pkg::DP_FOUND;
					state_nxt = S_SHIFT;
				end else if (stat.idx_at_end) begin
					cmd.op    = wsrq_pkg::DP_APPEND;
					state_nxt = S_DONE;
				end else begin
					cmd.op = wsrq_pkg::DP_SCAN_STEP;
				end
			end
			S_SHIFT: begin
				cmd.op = wsrq_pkg::DP_SHIFT_STEP;
				if (stat.idx_at_pos) begin
					state_nxt = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op    = wsrq_pkg::DP_PLACE;
				state_nxt = S_DONE;
			end
			S_POP: begin
				cmd.op = wsrq_pkg::DP_POP_STEP;
				if (stat.idx_at_end) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op    = wsrq_pkg::DP_EMIT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/wsrq_dp.sv =====
`timescale 1ns / 1ps
module wsrq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  wsrq_pkg::dp_cmd_t  cmd,
	input  wsrq_pkg::req_t     req_data,
	input  logic               dup_allowed,
	input  logic               rsp_ready,
	output wsrq_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	output wsrq_pkg::rsp_t     rsp_data
);

	localparam int AW = $clog2(wsrq_pkg::DEPTH);
	localparam int OW = wsrq_pkg::CNT_W;

	wsrq_pkg::entry_t mem [wsrq_pkg::DEPTH];
	wsrq_pkg::entry_t rd_q;
	wsrq_pkg::entry_t head_q;
	wsrq_pkg::entry_t new_e;
	wsrq_pkg::entry_t wdata;
	wsrq_pkg::rsp_t   rsp_q;

	logic [AW-1:0]                 raddr;
	logic [AW-1:0]                 waddr;
	logic                          we;
	logic [1:0]                    cmd_code_q;
	logic [wsrq_pkg::KEY_W-1:0]    key_q;
	logic [wsrq_pkg::PAY_W-1:0]    pay_q;
	logic [1:0]                    status_q;
	logic [OW-1:0]                 occ_q;
	logic [OW-1:0]                 occ_last;
	logic [AW-1:0]                 brk_q;
	logic [AW-1:0]                 brk_found;
	logic [AW-1:0]                 idx_q;
	logic [AW-1:0]                 pos_q;
	logic [wsrq_pkg::KEY_W-1:0]    prev_key_q;
	logic [wsrq_pkg::KEY_W-1:0]    diff;
	logic                          has_left;
	logic                          rsp_valid_q;

	assign new_e.key     = key_q;
	assign new_e.payload = pay_q;
	assign occ_last      = occ_q - OW'(1);
	assign diff          = key_q - rd_q.key;
	assign has_left      = (idx_q != '0);

	assign brk_found = brk_q
		+ AW'(has_left & wsrq_pkg::key_break(prev_key_q, key_q))
		+ AW'(wsrq_pkg::key_break(key_q, rd_q.key))
		- AW'(has_left & wsrq_pkg::key_break(prev_key_q, rd_q.key));

	assign stat.command    = cmd_code_q;
	assign stat.occ_zero   = (occ_q == '0);
	assign stat.occ_one    = (occ_q == OW'(1));
	assign stat.occ_full   = (occ_q == OW'(wsrq_pkg::DEPTH));
	assign stat.dup_hit    = !dup_allowed && (rd_q.key == key_q);
	assign stat.ahead      = diff[wsrq_pkg::KEY_W-1];
	assign stat.idx_at_end = (OW'(idx_q) == occ_last);
	assign stat.idx_at_pos = (idx_q == pos_q);
	assign stat.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		raddr = idx_q + AW'(1);
		waddr = idx_q + AW'(1);
		wdata = rd_q;
		we    = 1'b0;
		unique case (cmd.op)
			wsrq_pkg::DP_SCAN_START: begin
				raddr = '0;
			end
			wsrq_pkg::DP_FOUND: begin
				raddr = occ_last[AW-1:0];
			end
			wsrq_pkg::DP_APPEND: begin
				we    = 1'b1;
				waddr = occ_q[AW-1:0];
				wdata = new_e;
			end
			wsrq_pkg::DP_SHIFT_STEP: begin
				raddr = idx_q - AW'(1);
				we    = 1'b1;
			end
			wsrq_pkg::DP_PLACE: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = new_e;
			end
			wsrq_pkg::DP_POP_START: begin
				raddr = AW'(1);
			end
			wsrq_pkg::DP_POP_STEP: begin
				we    = 1'b1;
				waddr = idx_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			brk_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == wsrq_pkg::DP_EMIT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				wsrq_pkg::DP_FOUND: begin
					brk_q <= brk_found;
				end
				wsrq_pkg::DP_APPEND: begin
					occ_q <= occ_q + OW'(1);
					if (occ_q != '0) begin
						brk_q <= brk_q + AW'(wsrq_pkg::key_break(rd_q.key, key_q));
					end
				end
				wsrq_pkg::DP_PLACE: begin
					occ_q <= occ_q + OW'(1);
				end
				wsrq_pkg::DP_POP_STEP: begin
					if (idx_q == AW'(1)) begin
						brk_q <= brk_q - AW'(wsrq_pkg::key_break(head_q.key, rd_q.key));
					end
					if (stat.idx_at_end) begin
						occ_q <= occ_last;
					end
				end
				wsrq_pkg::DP_POP_ONE: begin
					occ_q <= '0;
					brk_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			wsrq_pkg::DP_LOAD: begin
				cmd_code_q <= req_data.command;
				key_q      <= req_data.key;
				pay_q      <= req_data.payload;
				status_q   <= wsrq_pkg::ST_OK;
			end
			wsrq_pkg::DP_SET_STATUS: begin
				status_q <= cmd.code;
			end
			wsrq_pkg::DP_SCAN_START: begin
				idx_q <= '0;
			end
			wsrq_pkg::DP_SCAN_STEP: begin
				prev_key_q <= rd_q.key;
				idx_q      <= idx_q + AW'(1);
			end
			wsrq_pkg::DP_FOUND: begin
				pos_q <= idx_q;
				idx_q <= occ_last[AW-1:0];
				if (idx_q == '0) begin
					head_q <= new_e;
				end
			end
			wsrq_pkg::DP_APPEND: begin
				if (occ_q == '0) begin
					head_q <= new_e;
				end
			end
			wsrq_pkg::DP_SHIFT_STEP: begin
				idx_q <= idx_q - AW'(1);
			end
			wsrq_pkg::DP_POP_START: begin
				idx_q <= AW'(1);
			end
			wsrq_pkg::DP_POP_STEP: begin
				idx_q <= idx_q + AW'(1);
				if (idx_q == AW'(1)) begin
					head_q <= rd_q;
				end
			end
			wsrq_pkg::DP_EMIT: begin
				rsp_q.status           <= status_q;
				rsp_q.entry_count      <= occ_q;
				rsp_q.head_valid       <= (occ_q != '0);
				rsp_q.head_key         <= (occ_q != '0) ? head_q.key : '0;
				rsp_q.head_payload     <= (occ_q != '0) ? head_q.payload : '0;
				rsp_q.keys_consecutive <= (brk_q == '0);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/wraparound_sorted_reorder_queue.sv =====
`timescale 1ns / 1ps
// A status request, a full or empty rejection, a pop of a single entry and an insert into an
// empty queue are settled without a walk over the entries; any other insert scans them from the
// front, and one placed ahead of an entry shifts the later ones back, while a pop from two or more
// shifts the rest forward. Requests are worked on one item at a time: the next one is taken only
// once the result of the last has been loaded, which waits while an earlier response is not taken.
// Reset clears the entry and break counts, the duplicates register and the handshakes only.
module wraparound_sorted_reorder_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  wsrq_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output wsrq_pkg::rsp_t rsp_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	wsrq_pkg::dp_cmd_t  cmd;
	wsrq_pkg::dp_stat_t stat;
	logic               dup_allowed_q;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == wsrq_pkg::REG_DUP_ALLOWED);
	assign prdata  = reg_sel ? {31'b0, dup_allowed_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_allowed_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			dup_allowed_q <= pwdata[0];
		end
	end

	wsrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wsrq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_data    (req_data),
		.dup_allowed (dup_allowed_q),
		.rsp_ready   (rsp_ready),
		.stat        (stat),
		.rsp_valid   (rsp_valid),
		.rsp_data    (rsp_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while an item was still being worked on");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.entry_count <= wsrq_pkg::DEPTH))
		else $error("entry count beyond the queue depth");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.head_valid == (rsp_data.entry_count != '0)))
		else $error("head valid disagrees with the entry count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status == wsrq_pkg::ST_FULL)) |->
		(rsp_data.entry_count == wsrq_pkg::DEPTH))
		else $error("full status reported below the queue depth");

	a_empty_consecutive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.entry_count == '0)) |-> rsp_data.keys_consecutive)
		else $error("empty queue reported as not consecutive");

endmodule
